// ===== rtl/gcdist_pkg.sv =====
// Shared widths, constants and the CORDIC angle table for the great-circle distance block.
`default_nettype none
package gcdist_pkg;

    localparam int LAT_W      = 24;
    localparam int LON_W      = 25;
    localparam int DIST_W     = 22;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 24;

    localparam int CORDIC_N = 31;
    localparam int SQRT_N   = 32;
    localparam int ATAN_W   = 30;

    // fixed-point working widths
    localparam int U_W   = 26;
    localparam int MAG_W = 25;
    localparam int RM_W  = 35;
    localparam int TH_W  = 36;
    localparam int XY_W  = 34;
    localparam int P_W   = 32;
    localparam int A_W   = 31;
    localparam int SQ_W  = 64;
    localparam int Z_W   = 34;
    localparam int ZC_W  = 32;

    localparam int Q_ONE = 1 << 30;

    localparam logic [63:0] RAD_SCALE = (64'd314159 << 44) / 64'd18000000;
    localparam logic [63:0] MILE_DEN  = 64'd1609 << 22;
    localparam logic [63:0] RECIP_MI  = (64'd1 << 32) / 64'd1609;

    localparam logic [ATAN_W-1:0] ATAN_TAB [0:CORDIC_N-1] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,
        30'd64,        30'd32,        30'd16,        30'd8,
        30'd4,         30'd2,         30'd1
    };

    typedef struct packed {
        logic                   ng;
        logic signed [TH_W-1:0] th;
    } rr_t;

endpackage
`default_nettype wire

// ===== rtl/gcdist_pipe.sv =====
// Haversine datapath: radians, range reduction, CORDIC sin/cos, square roots, atan2, scaling.
`default_nettype none
module gcdist_pipe (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire logic signed [gcdist_pkg::LAT_W-1:0] lat_from,
    input  wire logic signed [gcdist_pkg::LON_W-1:0] lon_from,
    input  wire logic signed [gcdist_pkg::LAT_W-1:0] lat_to,
    input  wire logic signed [gcdist_pkg::LON_W-1:0] lon_to,
    output logic                                     out_valid,
    output logic [gcdist_pkg::DIST_W-1:0]            distance_miles
);
    import gcdist_pkg::*;

    localparam int PRE_N  = 7;
    localparam int MID_N  = 6;
    localparam int POST_N = 6;
    localparam int DEPTH  = PRE_N + CORDIC_N + MID_N + SQRT_N + CORDIC_N + POST_N;
    localparam int LC     = CORDIC_N - 1;
    localparam int LS     = SQRT_N - 1;

    localparam logic [19:0] RS_LO = RAD_SCALE[19:0];
    localparam logic [18:0] RS_HI = RAD_SCALE[38:20];
    localparam logic signed [TH_W-1:0] PI_TH      = TH_W'(64'sd3373259426);
    localparam logic signed [TH_W-1:0] HALF_PI_TH = TH_W'(64'sd1686629713);
    localparam logic signed [XY_W-1:0] CORDIC_X0  = XY_W'(64'sd652032874);
    localparam logic signed [P_W:0]    ONE_S      = (P_W+1)'(Q_ONE);
    localparam logic [A_W-1:0]         ONE_A      = A_W'(Q_ONE);
    localparam logic [23:0]            DIST_K     = 24'd12742000;
    localparam logic [56:0]            ROUND_C    = 57'(MILE_DEN >> 1);
    localparam logic [34:0]            SAT_Q      = 35'(MILE_DEN);
    localparam logic [21:0]            RECIP      = 22'(RECIP_MI);
    localparam logic [10:0]            MI_K       = 11'd1609;
    localparam logic [12:0]            MI_K1      = 13'd1609;
    localparam logic [12:0]            MI_K2      = 13'd3218;

    function automatic rr_t rr_step(input rr_t v);
        rr_t r;
        r = v;
        if (v.th > HALF_PI_TH)
        begin
            r.th = v.th - PI_TH;
            r.ng = ~v.ng;
        end
        else if (v.th < -HALF_PI_TH)
        begin
            r.th = v.th + PI_TH;
            r.ng = ~v.ng;
        end
        return r;
    endfunction

    logic [DEPTH-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[DEPTH-1];

    // input capture
    logic signed [LAT_W-1:0] lat1_reg, lat2_reg;
    logic signed [LON_W-1:0] lon1_reg, lon2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat1_reg <= lat_from;
            lon1_reg <= lon_from;
            lat2_reg <= lat_to;
            lon2_reg <= lon_to;
        end
    end

    // angles: half dLat, half dLon, lat1, lat2
    logic signed [U_W-1:0]   u [0:3];
    logic [MAG_W-1:0]        mag_reg [0:3];
    logic                    ng1_reg [0:3];
    logic [MAG_W+19:0]       plo_reg [0:3];
    logic [MAG_W+18:0]       phi_reg [0:3];
    logic                    ng2_reg [0:3];
    logic [RM_W-1:0]         rm_reg  [0:3];
    logic                    ng3_reg [0:3];
    rr_t                     rr4_reg [0:3];
    rr_t                     rr5_reg [0:3];
    rr_t                     rr6_reg [0:3];

    assign u[0] = U_W'(lat2_reg) - U_W'(lat1_reg);
    assign u[1] = U_W'(lon2_reg) - U_W'(lon1_reg);
    assign u[2] = U_W'(lat1_reg);
    assign u[3] = U_W'(lat2_reg);

    logic signed [XY_W-1:0] cx_reg [0:3][0:LC];
    logic signed [XY_W-1:0] cy_reg [0:3][0:LC];
    logic signed [TH_W-1:0] cz_reg [0:3][0:LC];
    logic                   cn_reg [0:3][0:LC];

    for (genvar k = 0; k < 4; k++)
    begin : g_ang
        localparam int SH = (k < 2) ? 31 : 30;
        logic [63:0] full;

        assign full = (64'(phi_reg[k]) << 20) + 64'(plo_reg[k]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mag_reg[k] <= u[k][U_W-1] ? MAG_W'(-u[k]) : MAG_W'(u[k]);
                ng1_reg[k] <= u[k][U_W-1];
                plo_reg[k] <= mag_reg[k] * RS_LO;
                phi_reg[k] <= mag_reg[k] * RS_HI;
                ng2_reg[k] <= ng1_reg[k];
                rm_reg[k]  <= RM_W'(full >> SH);
                ng3_reg[k] <= ng2_reg[k];
                rr4_reg[k].ng <= 1'b0;
                rr4_reg[k].th <= ng3_reg[k] ? -$signed({1'b0, rm_reg[k]})
                                            : $signed({1'b0, rm_reg[k]});
                rr5_reg[k] <= rr_step(rr4_reg[k]);
                rr6_reg[k] <= rr_step(rr5_reg[k]);
            end
        end

        for (genvar i = 0; i < CORDIC_N; i++)
        begin : g_rot
            logic signed [XY_W-1:0] xi, yi;
            logic signed [TH_W-1:0] zi;
            logic                   ni;
            logic signed [TH_W-1:0] at;

            assign at = $signed(TH_W'(ATAN_TAB[i]));

            if (i == 0)
            begin : g_first
                assign xi = CORDIC_X0;
                assign yi = '0;
                assign zi = rr6_reg[k].th;
                assign ni = rr6_reg[k].ng;
            end
            else
            begin : g_next
                assign xi = cx_reg[k][i-1];
                assign yi = cy_reg[k][i-1];
                assign zi = cz_reg[k][i-1];
                assign ni = cn_reg[k][i-1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (zi >= 0)
                    begin
                        cx_reg[k][i] <= xi - (yi >>> i);
                        cy_reg[k][i] <= yi + (xi >>> i);
                        cz_reg[k][i] <= zi - at;
                    end
                    else
                    begin
                        cx_reg[k][i] <= xi + (yi >>> i);
                        cy_reg[k][i] <= yi - (xi >>> i);
                        cz_reg[k][i] <= zi + at;
                    end
                    cn_reg[k][i] <= ni;
                end
            end
        end
    end

    // haversine term
    logic signed [P_W-1:0]   s1_reg, s2_reg, ca_reg, cb_reg;
    logic signed [P_W-1:0]   sq1_reg, sq2_reg, cc_reg;
    logic signed [P_W-1:0]   sq1b_reg, t_reg;
    logic signed [P_W:0]     asum_reg;
    logic [A_W-1:0]          acl_reg;
    logic signed [2*P_W-1:0] pr1, pr2, pr3, pr4;

    assign pr1 = s1_reg * s1_reg;
    assign pr2 = s2_reg * s2_reg;
    assign pr3 = ca_reg * cb_reg;
    assign pr4 = sq2_reg * cc_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg   <= P_W'(cn_reg[0][LC] ? -cy_reg[0][LC] : cy_reg[0][LC]);
            s2_reg   <= P_W'(cn_reg[1][LC] ? -cy_reg[1][LC] : cy_reg[1][LC]);
            ca_reg   <= P_W'(cn_reg[2][LC] ? -cx_reg[2][LC] : cx_reg[2][LC]);
            cb_reg   <= P_W'(cn_reg[3][LC] ? -cx_reg[3][LC] : cx_reg[3][LC]);
            sq1_reg  <= P_W'(pr1 >>> 30);
            sq2_reg  <= P_W'(pr2 >>> 30);
            cc_reg   <= P_W'(pr3 >>> 30);
            sq1b_reg <= sq1_reg;
            t_reg    <= P_W'(pr4 >>> 30);
            asum_reg <= (P_W+1)'(sq1b_reg) + (P_W+1)'(t_reg);
            if (asum_reg < 0)
                acl_reg <= '0;
            else if (asum_reg > ONE_S)
                acl_reg <= ONE_A;
            else
                acl_reg <= A_W'(asum_reg);
        end
    end

    // integer square roots of a and 1-a, both scaled by 2^30
    logic [SQ_W-1:0] qn_reg [0:1][0:LS];
    logic [SQ_W-1:0] qr_reg [0:1][0:LS];
    logic [SQ_W-1:0] n0_reg [0:1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n0_reg[0] <= SQ_W'(acl_reg) << 30;
            n0_reg[1] <= SQ_W'(ONE_A - acl_reg) << 30;
        end
    end

    for (genvar k = 0; k < 2; k++)
    begin : g_sqrt
        for (genvar i = 0; i < SQRT_N; i++)
        begin : g_bit
            localparam logic [SQ_W-1:0] SB = SQ_W'(1) << (2 * SQRT_N - 2 - 2 * i);
            logic [SQ_W-1:0] ni, ri, rb;

            if (i == 0)
            begin : g_first
                assign ni = n0_reg[k];
                assign ri = '0;
            end
            else
            begin : g_next
                assign ni = qn_reg[k][i-1];
                assign ri = qr_reg[k][i-1];
            end

            assign rb = ri + SB;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (ni >= rb)
                    begin
                        qn_reg[k][i] <= ni - rb;
                        qr_reg[k][i] <= (ri >> 1) + SB;
                    end
                    else
                    begin
                        qn_reg[k][i] <= ni;
                        qr_reg[k][i] <= ri >> 1;
                    end
                end
            end
        end
    end

    // atan2(sqrt(a), sqrt(1-a)) by vectoring
    logic signed [XY_W-1:0] ax_reg [0:LC];
    logic signed [XY_W-1:0] ay_reg [0:LC];
    logic signed [Z_W-1:0]  az_reg [0:LC];

    for (genvar i = 0; i < CORDIC_N; i++)
    begin : g_vec
        logic signed [XY_W-1:0] xi, yi;
        logic signed [Z_W-1:0]  zi;
        logic signed [Z_W-1:0]  at;

        assign at = $signed(Z_W'(ATAN_TAB[i]));

        if (i == 0)
        begin : g_first
            assign xi = $signed(XY_W'(qr_reg[1][LS]));
            assign yi = $signed(XY_W'(qr_reg[0][LS]));
            assign zi = '0;
        end
        else
        begin : g_next
            assign xi = ax_reg[i-1];
            assign yi = ay_reg[i-1];
            assign zi = az_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (yi >= 0)
                begin
                    ax_reg[i] <= xi + (yi >>> i);
                    ay_reg[i] <= yi - (xi >>> i);
                    az_reg[i] <= zi + at;
                end
                else
                begin
                    ax_reg[i] <= xi - (yi >>> i);
                    ay_reg[i] <= yi + (xi >>> i);
                    az_reg[i] <= zi - at;
                end
            end
        end
    end

    // scale to 1/256 mile, round half up, divide by 1609 via reciprocal, saturate on overflow
    logic [ZC_W-1:0]   zc_reg;
    logic [55:0]       nm_reg;
    logic [56:0]       nsum;
    logic [34:0]       qfull;
    logic [32:0]       qq_reg, qq2_reg;
    logic              sat_reg, sat2_reg, sat3_reg;
    logic [54:0]       pm_reg;
    logic [22:0]       qe;
    logic [22:0]       qe_reg;
    logic [33:0]       qe_mul;
    logic [33:0]       rem_full;
    logic [12:0]       rem_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [22:0]       dsum;

    assign nsum     = 57'(nm_reg) + ROUND_C;
    assign qfull    = 35'(nsum >> 22);
    assign qe       = 23'(pm_reg >> 32);
    assign qe_mul   = qe * MI_K;
    assign rem_full = 34'(qq2_reg) - qe_mul;
    assign dsum     = qe_reg + ((rem_reg >= MI_K2) ? 23'd2 :
                                (rem_reg >= MI_K1) ? 23'd1 : 23'd0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zc_reg   <= (az_reg[LC] < 0) ? '0 : ZC_W'(az_reg[LC]);
            nm_reg   <= zc_reg * DIST_K;
            qq_reg   <= qfull[32:0];
            sat_reg  <= qfull >= SAT_Q;
            pm_reg   <= qq_reg * RECIP;
            qq2_reg  <= qq_reg;
            sat2_reg <= sat_reg;
            qe_reg   <= qe;
            rem_reg  <= rem_full[12:0];
            sat3_reg <= sat2_reg;
            dist_reg <= sat3_reg ? '1 : DIST_W'(dsum);
        end
    end

    assign distance_miles = dist_reg;

endmodule
`default_nettype wire

// ===== rtl/great_circle_distance.sv =====
// Top level: stream ports, output register and skid stage around the haversine pipeline.
//
//  Channel   Dir  tdata fields (low bit up)                        tuser  tlast
//  s_axis    in   lat_from[23:0] lon_from[48:24] lat_to[72:49]      -      -
//                 lon_to[97:73], zero pad to 104
//  m_axis    out  distance_miles[21:0], zero pad to 24             -      -
//
// One transaction per cycle while the skid stage is empty.
// The pipeline holds the four 31-step CORDIC rotators, the two 32-step square roots and
// the 31-step vectoring CORDIC, each step one register stage.
// rst_n clears all valid bits; payload registers are not reset.
// A result not taken goes to the skid stage; the pipeline then freezes until it drains.
`default_nettype none
module great_circle_distance (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // lat_from, lon_from, lat_to, lon_to
    input  wire logic [gcdist_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // distance_miles
    output logic [gcdist_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import gcdist_pkg::*;

    logic                    en;
    logic                    pipe_valid;
    logic [DIST_W-1:0]       pipe_dist;
    logic                    out_valid_reg, skid_valid_reg;
    logic [DIST_W-1:0]       out_data_reg, skid_data_reg;
    logic                    take;

    assign en       = ~skid_valid_reg;
    assign s_tready = en;
    assign take     = out_valid_reg & m_tready;

    gcdist_pipe u_pipe (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (s_tvalid),
        .lat_from       ($signed(s_tdata[23:0])),
        .lon_from       ($signed(s_tdata[48:24])),
        .lat_to         ($signed(s_tdata[72:49])),
        .lon_to         ($signed(s_tdata[97:73])),
        .out_valid      (pipe_valid),
        .distance_miles (pipe_dist)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (en && pipe_valid)
        begin
            if (!out_valid_reg || take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg && take)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && pipe_valid)
        begin
            if (!out_valid_reg || take)
                out_data_reg <= pipe_dist;
            else
                skid_data_reg <= pipe_dist;
        end
        else if (skid_valid_reg && take)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_data_reg);

endmodule
`default_nettype wire
